// File: rtl/escaped_frame_receiver_assert.svh
// Assertion macros used by the escaped frame receiver RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ESCAPED_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_ASSERT_SVH

// The condition must never be true outside reset.
`define EFR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define EFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/efr_pkg.sv
// Package for the escaped frame receiver: framing codes, parser states
// and the structs passed between the receiver's submodules. No dependencies.
package efr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;

    localparam logic [7:0] START_BYTE  = 8'hFF;
    localparam logic [7:0] END_BYTE    = 8'hFE;
    localparam logic [7:0] ESCAPE_BYTE = 8'hFD;
    localparam logic [7:0] ESCAPE_SET  = 8'h80;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_RECV,
        RX_ESC
    } t_rx_mode;

    // One write into the frame store; the entry index travels beside it.
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] data;
    } t_store_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: rtl/escaped_frame_receiver.sv
// Escaped frame receiver top level: ties the parser front end, the frame
// descriptor queue and the playback back end together. Uses efr_pkg.
//
// Input channel (i_valid/o_ready, i_line_byte): one raw serial line word per
// handshake. 255 starts a frame, 254 ends it, 253 escapes the following word,
// which is stored with bit 7 set. The last stored word of a frame is an
// additive checksum; a frame is kept only when all its stored words sum to
// zero modulo 256 and it carries at least one payload word.
// Output channel (o_valid/i_ready, o_payload_byte, o_frame_end): the payload
// words of each kept frame in order, without the checksum, with o_frame_end
// set on the final word.
// Throughput: one line word per cycle while fewer than two completed frames
// wait for playback; the frame store has two banks, so one frame can be
// received while the previous one plays out. With two frames pending,
// o_ready drops until playback of the older one finishes.
// Playback: the end word pushes the frame's descriptor into the queue, and
// each payload word is read from the store into the output register, one
// word per cycle unless the output stalls, set by the store's single read port.
// Reset (synchronous, active low) returns the parser to idle, empties the
// queue and clears the output valid. A stall on the output simply holds the
// current word and pauses playback.
module escaped_frame_receiver import efr_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_line_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_end
);

    `include "escaped_frame_receiver_assert.svh"

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int FW = $clog2(MAX_FRAME_BYTES + 1);

    t_store_wr     wr;
    logic [AW-1:0] wr_idx;
    logic          push, pop, take;
    logic [FW:0]   push_desc, head_desc;
    t_q_status     q_status;

    // The front may only run while its current bank is free, which is the
    // case whenever the queue holds fewer than two frames.
    assign o_ready = !q_status.full;
    assign take    = i_valid && o_ready;

    efr_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .AW(AW),
        .FW(FW)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_take(take),
        .i_line_byte(i_line_byte),
        .o_wr(wr),
        .o_wr_idx(wr_idx),
        .o_push(push),
        .o_push_desc(push_desc)
    );

    efr_queue #(
        .DW(FW + 1)
    ) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_data(push_desc),
        .i_pop(pop),
        .o_data(head_desc),
        .o_status(q_status)
    );

    efr_back #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .AW(AW),
        .FW(FW)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_wr(wr),
        .i_wr_idx(wr_idx),
        .i_head_desc(head_desc),
        .i_q_status(q_status),
        .o_pop(pop),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_payload_byte(o_payload_byte),
        .o_frame_end(o_frame_end)
    );

    // A frame is never released into a full queue.
    `EFR_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, push && q_status.full, "push into full queue")
    // Playback never retires a frame that is not there.
    `EFR_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, pop && q_status.empty, "pop from empty queue")
    // The parser never writes into the bank that is being played out.
    `EFR_ASSERT_IMPLY(a_bank_clash, i_clk, i_rst_n, wr.en && !q_status.empty, wr.bank != head_desc[FW], "write into playback bank")

endmodule

// File: rtl/efr_front.sv
// Front end of the escaped frame receiver: parses line words, writes the
// frame store and pushes checked frame descriptors. Depends on efr_pkg.
module efr_front import efr_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int AW = $clog2(MAX_FRAME_BYTES),
    parameter int FW = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_line_byte,
    output t_store_wr     o_wr,
    output logic [AW-1:0] o_wr_idx,
    output logic          o_push,
    output logic [FW:0]   o_push_desc
);

    localparam logic [FW-1:0] FILL_MAX = FW'(MAX_FRAME_BYTES);

    t_rx_mode      r_mode, n_mode;
    logic [FW-1:0] r_fill, n_fill;
    logic [7:0]    r_sum, n_sum;
    logic          r_bank, n_bank;

    logic       is_start, is_end, is_esc, is_high, is_full;
    logic [7:0] store_data;

    assign is_start = (i_line_byte == START_BYTE);
    assign is_end   = (i_line_byte == END_BYTE);
    assign is_esc   = (i_line_byte == ESCAPE_BYTE);
    assign is_high  = (i_line_byte >= ESCAPE_BYTE);
    assign is_full  = (r_fill == FILL_MAX);

    // Next state.
    always_comb begin
        n_mode = r_mode;
        if (i_take) begin
            unique case (r_mode)
                RX_IDLE: begin
                    if (is_start) n_mode = RX_RECV;
                end
                RX_RECV: begin
                    if (is_start)       n_mode = RX_RECV;
                    else if (is_end)    n_mode = RX_IDLE;
                    else if (is_esc)    n_mode = RX_ESC;
                    else if (is_full)   n_mode = RX_IDLE;
                end
                RX_ESC: begin
                    if (is_high || is_full) n_mode = RX_IDLE;
                    else                    n_mode = RX_RECV;
                end
                default: n_mode = RX_IDLE;
            endcase
        end
    end

    // Store writes, running sum and frame release.
    always_comb begin
        o_wr        = '0;
        o_push      = 1'b0;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_bank      = r_bank;
        store_data  = (r_mode == RX_ESC) ? (i_line_byte | ESCAPE_SET) : i_line_byte;
        if (i_take) begin
            unique case (r_mode)
                RX_IDLE: begin
                    if (is_start) begin
                        n_fill = '0;
                        n_sum  = '0;
                    end
                end
                RX_RECV: begin
                    if (is_start) begin
                        n_fill = '0;
                        n_sum  = '0;
                    end else if (is_end) begin
                        if (r_sum == 8'd0 && r_fill >= FW'(2)) begin
                            o_push = 1'b1;
                            n_bank = ~r_bank;
                        end
                    end else if (!is_esc && !is_full) begin
                        o_wr.en = 1'b1;
                    end
                end
                RX_ESC: begin
                    if (!is_high && !is_full) o_wr.en = 1'b1;
                end
                default: ;
            endcase
        end
        o_wr.bank = r_bank;
        o_wr.data = store_data;
        if (o_wr.en) begin
            n_fill = r_fill + FW'(1);
            n_sum  = r_sum + store_data;
        end
    end

    assign o_wr_idx    = r_fill[AW-1:0];
    assign o_push_desc = {r_bank, r_fill - FW'(1)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= RX_IDLE;
            r_fill <= '0;
            r_sum  <= '0;
            r_bank <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_fill <= n_fill;
            r_sum  <= n_sum;
            r_bank <= n_bank;
        end
    end

endmodule

// File: rtl/efr_queue.sv
// Two-entry descriptor queue between the front and back of the receiver.
// Depends on efr_pkg for the status struct.
module efr_queue import efr_pkg::*; #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output t_q_status     o_status
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_data         = r_mem[r_rp];
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);

endmodule

// File: rtl/efr_back.sv
// Back end of the escaped frame receiver: holds the double-banked frame
// store and plays queued frames out through the output register. Uses efr_pkg.
module efr_back import efr_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int AW = $clog2(MAX_FRAME_BYTES),
    parameter int FW = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_store_wr     i_wr,
    input  logic [AW-1:0] i_wr_idx,
    input  logic [FW:0]   i_head_desc,
    input  t_q_status     i_q_status,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_payload_byte,
    output logic          o_frame_end
);

    localparam int DEPTH = 2 ** (AW + 1);

    logic [7:0]    r_store [DEPTH];
    logic [AW-1:0] r_idx;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_end;

    logic          head_bank;
    logic [FW-1:0] head_cnt;
    logic          issue, last;

    assign head_bank = i_head_desc[FW];
    assign head_cnt  = i_head_desc[FW-1:0];
    assign issue     = !i_q_status.empty && (!r_out_valid || i_ready);
    assign last      = (FW'(r_idx) + FW'(1) == head_cnt);
    assign o_pop     = issue && last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_store[{i_wr.bank, i_wr_idx}] <= i_wr.data;
        if (issue) begin
            r_out_byte <= r_store[{head_bank, r_idx}];
            r_out_end  <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_idx       <= last ? '0 : r_idx + AW'(1);
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_frame_end    = r_out_end;

endmodule
